>>> rtl/allpass_fourth_order_filter_assert.svh
// Assertion macros for the allpass filter; define NO_ASSERTIONS to drop them.
`ifndef ALLPASS_FOURTH_ORDER_FILTER_ASSERT_SVH
`define ALLPASS_FOURTH_ORDER_FILTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge out of reset.
`define APF4_CHECK(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("apf4 check failed");

// Check a condition in the cycle after a trigger.
`define APF4_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("apf4 sequence check failed");

`else

`define APF4_CHECK(lbl, expr)
`define APF4_CHECK_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/apf4_pkg.sv
package apf4_pkg;

    localparam int COEF_W    = 18;
    localparam int CH_IN_W   = 4;
    localparam int NUM_COEF  = 4;
    localparam int TAPS      = 4;
    localparam int SLOTS     = 2 * TAPS;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TWO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_THREE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FOUR  = 2'd3;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [CH_IN_W-1:0]       t_chan;

endpackage

>>> rtl/apf4_ram.sv
module apf4_ram #(
    parameter int WIDTH = 192,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/allpass_fourth_order_filter.sv
// Multichannel fourth-order allpass filter.
// Input beat: i_sample_in and i_channel under i_valid / o_stall. Output beat:
// o_sample_out and o_channel_out under o_valid / i_stall. Coefficients are
// written through i_cfg_we / i_cfg_index / i_cfg_data; the user must write
// them only while the block is idle, which the block itself does not enforce.
// Each channel keeps its last four inputs and outputs in one word of a
// synchronous RAM; a beat reads that word, forms the result over three stages
// and writes the shifted history back as it enters the output register. A beat
// passes stages s1, s2 and s3 into the output register, which drives o_valid.
// Throughput: one beat per cycle while i_stall does not hold the output and
// each beat's channel differs from those of the three beats ahead of it; a
// beat whose channel is still in the pipeline stalls until its write-back.
// Reset clears the coefficients and the valid bits of the pipeline and of each
// channel, so every history reads as zero; no clearing pass is needed.
// While the output beat waits under i_stall, the pipeline holds and o_stall
// rises; a finished beat is never dropped or repeated.
`include "allpass_fourth_order_filter_assert.svh"

module allpass_fourth_order_filter #(
    parameter int CHANNELS       = 16,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_in,
    input  logic [apf4_pkg::CH_IN_W-1:0]         i_channel,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [SAMPLE_BITS-1:0]        o_sample_out,
    output logic [apf4_pkg::CH_IN_W-1:0]         o_channel_out,
    input  logic                                 i_cfg_we,
    input  logic [apf4_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [apf4_pkg::COEF_W-1:0]          i_cfg_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WORD_W = apf4_pkg::SLOTS * SB;
    localparam int DIFF_W = SB + 1;
    localparam int PROD_W = apf4_pkg::COEF_W + DIFF_W;
    localparam int TERM_W = (PROD_W > SB + COEF_FRAC_BITS) ? PROD_W : SB + COEF_FRAC_BITS;
    localparam int ACC_W  = TERM_W + 3;
    localparam int RND_W  = ACC_W - COEF_FRAC_BITS;
    localparam int NUM_IN_CH = 2 ** apf4_pkg::CH_IN_W;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [SB-1:0]    SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0]    SMIN = {1'b1, {(SB-1){1'b0}}};

    function automatic logic [CH_W-1:0] f_ch_map(input logic [apf4_pkg::CH_IN_W-1:0] ch);
        int m;
        m = int'(ch);
        for (int q = 1; q < NUM_IN_CH; q++) begin
            if (int'(ch) >= q * CHANNELS) begin
                m = int'(ch) - q * CHANNELS;
            end
        end
        return CH_W'(m);
    endfunction

    apf4_pkg::t_coef r_coef [apf4_pkg::NUM_COEF];

    logic                         en;
    logic                         hazard;
    logic                         accept;
    logic [CH_W-1:0]              in_addr;
    logic [CHANNELS-1:0]          r_hv;

    logic                         r_s1_v;
    logic signed [SB-1:0]         r_s1_x;
    logic [apf4_pkg::CH_IN_W-1:0] r_s1_ch;
    logic [CH_W-1:0]              r_s1_addr;
    logic                         r_s1_hvld;

    logic                         r_s2_v;
    logic signed [PROD_W-1:0]     r_s2_p [apf4_pkg::NUM_COEF];
    logic signed [SB-1:0]         r_s2_xt;
    logic [4*SB-1:0]              r_s2_xs;
    logic [3*SB-1:0]              r_s2_ys;
    logic [apf4_pkg::CH_IN_W-1:0] r_s2_ch;
    logic [CH_W-1:0]              r_s2_addr;

    logic                         r_s3_v;
    logic signed [ACC_W-1:0]      r_s3_a;
    logic signed [ACC_W-1:0]      r_s3_b;
    logic signed [ACC_W-1:0]      r_s3_c;
    logic [4*SB-1:0]              r_s3_xs;
    logic [3*SB-1:0]              r_s3_ys;
    logic [apf4_pkg::CH_IN_W-1:0] r_s3_ch;
    logic [CH_W-1:0]              r_s3_addr;

    logic                         r_out_v;
    logic signed [SB-1:0]         r_out_y;
    logic [apf4_pkg::CH_IN_W-1:0] r_out_ch;

    logic [WORD_W-1:0]            rdata;
    logic [WORD_W-1:0]            hist;
    logic signed [SB-1:0]         xh [apf4_pkg::TAPS];
    logic signed [SB-1:0]         yh [apf4_pkg::TAPS];
    logic signed [DIFF_W-1:0]     dif [apf4_pkg::NUM_COEF];
    logic signed [PROD_W-1:0]     prod [apf4_pkg::NUM_COEF];
    logic signed [ACC_W-1:0]      acc;
    logic signed [RND_W-1:0]      rnd;
    logic signed [SB-1:0]         y;
    logic                         mem_we;
    logic [WORD_W-1:0]            wdata;

    assign en      = !(r_out_v && i_stall);
    assign in_addr = f_ch_map(i_channel);
    assign hazard  = (r_s1_v && r_s1_addr == in_addr) ||
                     (r_s2_v && r_s2_addr == in_addr) ||
                     (r_s3_v && r_s3_addr == in_addr);
    assign o_stall = !en || hazard;
    assign accept  = i_valid && !o_stall;

    apf4_ram #(
        .WIDTH(WORD_W),
        .DEPTH(CHANNELS)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_s3_addr),
        .i_wdata(wdata),
        .i_re   (accept),
        .i_raddr(in_addr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < apf4_pkg::NUM_COEF; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                apf4_pkg::CFG_COEF_ONE:   r_coef[0] <= i_cfg_data;
                apf4_pkg::CFG_COEF_TWO:   r_coef[1] <= i_cfg_data;
                apf4_pkg::CFG_COEF_THREE: r_coef[2] <= i_cfg_data;
                apf4_pkg::CFG_COEF_FOUR:  r_coef[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        hist = r_s1_hvld ? rdata : '0;
        for (int k = 0; k < apf4_pkg::TAPS; k++) begin
            xh[k] = hist[k*SB +: SB];
            yh[k] = hist[(k + apf4_pkg::TAPS)*SB +: SB];
        end
        dif[0] = DIFF_W'(xh[2]) - DIFF_W'(yh[0]);
        dif[1] = DIFF_W'(xh[1]) - DIFF_W'(yh[1]);
        dif[2] = DIFF_W'(xh[0]) - DIFF_W'(yh[2]);
        dif[3] = DIFF_W'(r_s1_x) - DIFF_W'(yh[3]);
        for (int k = 0; k < apf4_pkg::NUM_COEF; k++) begin
            prod[k] = PROD_W'(r_coef[k]) * PROD_W'(dif[k]);
        end
    end

    always_comb begin
        acc = r_s3_a + r_s3_b + r_s3_c;
        rnd = RND_W'(acc >>> COEF_FRAC_BITS);
        if (rnd[RND_W-1:SB-1] == '0 || rnd[RND_W-1:SB-1] == '1) begin
            y = rnd[SB-1:0];
        end else if (rnd[RND_W-1]) begin
            y = SMIN;
        end else begin
            y = SMAX;
        end
    end

    assign mem_we = en && r_s3_v;
    assign wdata  = {r_s3_ys, y, r_s3_xs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_hv    <= '0;
        end else if (en) begin
            r_s1_v  <= accept;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_out_v <= r_s3_v;
            if (r_s3_v) begin
                r_hv[r_s3_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x    <= i_sample_in;
            r_s1_ch   <= i_channel;
            r_s1_addr <= in_addr;
            r_s1_hvld <= r_hv[in_addr];
        end
        if (en) begin
            for (int k = 0; k < apf4_pkg::NUM_COEF; k++) begin
                r_s2_p[k] <= prod[k];
            end
            r_s2_xt   <= xh[3];
            r_s2_xs   <= {xh[2], xh[1], xh[0], r_s1_x};
            r_s2_ys   <= {yh[2], yh[1], yh[0]};
            r_s2_ch   <= r_s1_ch;
            r_s2_addr <= r_s1_addr;

            r_s3_a    <= ACC_W'(r_s2_p[0]) + ACC_W'(r_s2_p[1]);
            r_s3_b    <= ACC_W'(r_s2_p[2]) + ACC_W'(r_s2_p[3]);
            r_s3_c    <= (ACC_W'(r_s2_xt) <<< COEF_FRAC_BITS) + HALF;
            r_s3_xs   <= r_s2_xs;
            r_s3_ys   <= r_s2_ys;
            r_s3_ch   <= r_s2_ch;
            r_s3_addr <= r_s2_addr;

            if (r_s3_v) begin
                r_out_y  <= y;
                r_out_ch <= r_s3_ch;
            end
        end
    end

    assign o_valid       = r_out_v;
    assign o_sample_out  = r_out_y;
    assign o_channel_out = r_out_ch;

    `APF4_CHECK(a_s1_s2_apart, !(r_s1_v && r_s2_v && r_s1_addr == r_s2_addr))
    `APF4_CHECK(a_s1_s3_apart, !(r_s1_v && r_s3_v && r_s1_addr == r_s3_addr))
    `APF4_CHECK(a_s2_s3_apart, !(r_s2_v && r_s3_v && r_s2_addr == r_s3_addr))
    `APF4_CHECK_NEXT(a_accept_enters, i_valid && !o_stall, r_s1_v)
    `APF4_CHECK_NEXT(a_stall_holds, r_out_v && i_stall, r_out_v && $stable(r_s3_v) && $stable(r_s1_v))

endmodule
